// ----- src/bitmap_block_allocator_unit_assert.svh -----
// Assertion macros shared by the bitmap block allocator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bba_pkg.sv -----
// Shared constants for the bitmap block allocator: field widths, command codes,
// default sizing. No dependencies.
package bba_pkg;

    localparam int CMD_W  = 2;
    localparam int POS_W  = 12;
    localparam int SIZE_W = 13;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;
    localparam int ADDRESSABLE = 4096;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd2;

    localparam int MAX_BLOCKS_DEFAULT = 4096;
    localparam int WORD_BITS_DEFAULT  = 32;

endpackage

// ----- src/bba_cmd_if.sv -----
// Command channel of the bitmap block allocator (valid/ready plus payload).
// Depends on bba_pkg.
interface bba_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [bba_pkg::CMD_W-1:0] command;
    logic [bba_pkg::POS_W-1:0] position;

    modport source (output valid, command, position, input ready);
    modport sink   (input valid, command, position, output ready);
endinterface

// ----- src/bba_res_if.sv -----
// Result channel of the bitmap block allocator (valid/ready plus payload).
// Depends on bba_pkg.
interface bba_res_if;
    logic                      valid;
    logic                      ready;
    logic                      ok;
    logic [bba_pkg::POS_W-1:0] granted_block;

    modport source (output valid, ok, granted_block, input ready);
    modport sink   (input valid, ok, granted_block, output ready);
endinterface

// ----- src/bba_bitmap_ram.sv -----
// Usage bitmap storage: one write port, one read port with registered data.
// No dependencies.
module bba_bitmap_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int AW    = 7
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/bba_word_scan.sv -----
// Word scanner: finds the lowest free bit of one bitmap word inside a
// valid-bit mask and builds the word with that bit marked used. No dependencies.
module bba_word_scan #(
    parameter int WORD_BITS = 32,
    parameter int IDX_W     = 5
) (
    input  logic [WORD_BITS-1:0] word_data,
    input  logic [WORD_BITS-1:0] valid_mask,
    output logic                 found,
    output logic [IDX_W-1:0]     bit_idx,
    output logic [WORD_BITS-1:0] set_word
);

    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] lowest;

    // Isolate the lowest set bit of the free vector.
    assign free_bits = ~word_data & valid_mask;
    assign lowest    = free_bits & (~free_bits + WORD_BITS'(1));
    assign found     = |free_bits;
    assign set_word  = word_data | lowest;

    // Encode the one-hot position: each index bit ORs the positions that carry it.
    always_comb
    begin
        logic [IDX_W-1:0] idx_v;
        idx_v = '0;
        for (int j = 0; j < IDX_W; j++)
        begin
            for (int i = 0; i < WORD_BITS; i++)
            begin
                if (((i >> j) & 1) != 0)
                begin
                    idx_v[j] = idx_v[j] | lowest[i];
                end
            end
        end
        bit_idx = idx_v;
    end

endmodule

// ----- src/bitmap_block_allocator_unit.sv -----
// First-fit bitmap block allocator. One usage bit per block lives in an on-chip
// RAM of ceil(MAX_BLOCKS/WORD_BITS) words (WORD_BITS must be a power of two).
// After reset a clearing pass writes every word free, one word per cycle; no
// item is taken until it is done. Items are handled one at a time. Free and
// reserve reach the result register through a RAM read, a modify/write and a
// load. An unused code, or a free or reserve of a block that does not exist,
// goes straight to the load. Allocate starts at a hint word (everything below
// it is known used) and examines one word at a time, a RAM read and then a
// pass through the word scanner. A grant ends the scan as soon as the scan
// check finds a free bit; a refusal once the read step meets a word beyond
// the search limit. The sequencer returns to idle before the next item can be
// taken. The result sits in an output register, so the next item may be
// accepted while it waits; a finished item holds until that register is
// free. Depends on bba_pkg, bba_cmd_if, bba_res_if, bba_bitmap_ram,
// bba_word_scan and bitmap_block_allocator_unit_assert.svh.
`include "bitmap_block_allocator_unit_assert.svh"

module bitmap_block_allocator_unit #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEFAULT,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [bba_pkg::SIZE_W-1:0] cfg_wdata,
    bba_cmd_if.sink                    request,
    bba_res_if.source                  response
);

    localparam int LOG       = $clog2(WORD_BITS);
    localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int WCNT_W    = AW + 1;
    localparam int CAP       = (MAX_BLOCKS < bba_pkg::ADDRESSABLE) ?
                               MAX_BLOCKS : bba_pkg::ADDRESSABLE;
    localparam int CMP_W     = (WCNT_W > bba_pkg::SIZE_W) ? WCNT_W : bba_pkg::SIZE_W;
    localparam int GB_W      = AW + LOG;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_MOD_RD,
        ST_MOD_WR,
        ST_DONE
    } state_t;

    state_t                       state_reg;
    logic [bba_pkg::SIZE_W-1:0]   size_reg;
    logic [WCNT_W-1:0]            scan_word_reg;
    logic [AW-1:0]                hint_reg;
    logic [bba_pkg::CMD_W-1:0]    cmd_reg;
    logic [bba_pkg::POS_W-1:0]    pos_reg;
    logic                         res_ok_reg;
    logic [bba_pkg::POS_W-1:0]    res_block_reg;
    logic                         out_valid_reg;
    logic                         out_ok_reg;
    logic [bba_pkg::POS_W-1:0]    out_block_reg;

    logic [bba_pkg::SIZE_W-1:0]   limit;
    logic [bba_pkg::SIZE_W-1:0]   lim_words;
    logic [LOG-1:0]               lim_rem;
    logic                         word_full_range;
    logic                         word_in_range;
    logic [WORD_BITS-1:0]         scan_mask;
    logic [AW-1:0]                pos_word;
    logic [WORD_BITS-1:0]         pos_bit;
    logic                         pos_exists;
    logic [GB_W-1:0]              grant_full;
    logic                         load_out;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [WORD_BITS-1:0]         ram_wdata;
    logic                         ram_re;
    logic [AW-1:0]                ram_raddr;
    logic [WORD_BITS-1:0]         ram_rdata;

    logic                         scan_found;
    logic [LOG-1:0]               scan_idx;
    logic [WORD_BITS-1:0]         scan_set_word;

    // Search limit: size in use, saturated at capacity and at what 12 bits can name.
    assign limit     = (32'(size_reg) > 32'(CAP)) ? bba_pkg::SIZE_W'(CAP) : size_reg;
    assign lim_words = limit >> LOG;
    assign lim_rem   = limit[LOG-1:0];

    // A word is fully inside the limit, partly inside (last word), or beyond it.
    assign word_full_range = CMP_W'(scan_word_reg) < CMP_W'(lim_words);
    assign word_in_range   = word_full_range ||
                             ((CMP_W'(scan_word_reg) == CMP_W'(lim_words)) &&
                              (lim_rem != '0));
    assign scan_mask       = word_full_range ? '1 :
                             ((WORD_BITS'(1) << lim_rem) - WORD_BITS'(1));

    assign pos_word   = AW'(pos_reg >> LOG);
    assign pos_bit    = WORD_BITS'(1) << pos_reg[LOG-1:0];
    assign pos_exists = 32'(request.position) < 32'(MAX_BLOCKS);
    assign grant_full = {scan_word_reg[AW-1:0], scan_idx};

    // A finished item moves to the output register when it is empty or drains now.
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || response.ready);

    // Bitmap RAM port control.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = scan_word_reg[AW-1:0];
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = scan_word_reg[AW-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_SCAN_RD:
            begin
                ram_re = word_in_range;
            end
            ST_SCAN_CHK:
            begin
                ram_we    = scan_found;
                ram_wdata = scan_set_word;
            end
            ST_MOD_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = pos_word;
            end
            ST_MOD_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_word;
                ram_wdata = (cmd_reg == bba_pkg::CMD_RESERVE) ?
                            (ram_rdata | pos_bit) : (ram_rdata & ~pos_bit);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    bba_bitmap_ram #(
        .DEPTH (NUM_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    bba_word_scan #(
        .WORD_BITS (WORD_BITS),
        .IDX_W     (LOG)
    ) u_scan (
        .word_data  (ram_rdata),
        .valid_mask (scan_mask),
        .found      (scan_found),
        .bit_idx    (scan_idx),
        .set_word   (scan_set_word)
    );

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= bba_pkg::SIZE_RESET;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
        end
    end

    // Sequencer with its registered results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            scan_word_reg <= '0;
            hint_reg      <= '0;
            cmd_reg       <= bba_pkg::CMD_ALLOC;
            pos_reg       <= '0;
            res_ok_reg    <= 1'b0;
            res_block_reg <= '0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_block_reg <= '0;
        end
        else
        begin
            // Load a finished item, or drop the output item once taken.
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                out_ok_reg    <= res_ok_reg;
                out_block_reg <= res_block_reg;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    if (scan_word_reg == WCNT_W'(NUM_WORDS - 1))
                    begin
                        scan_word_reg <= '0;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        scan_word_reg <= scan_word_reg + WCNT_W'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (request.valid)
                    begin
                        cmd_reg       <= request.command;
                        pos_reg       <= request.position;
                        res_ok_reg    <= 1'b1;
                        res_block_reg <= '0;
                        scan_word_reg <= {1'b0, hint_reg};
                        case (request.command)
                            bba_pkg::CMD_ALLOC:
                            begin
                                state_reg <= ST_SCAN_RD;
                            end
                            bba_pkg::CMD_FREE,
                            bba_pkg::CMD_RESERVE:
                            begin
                                state_reg <= pos_exists ? ST_MOD_RD : ST_DONE;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SCAN_RD:
                begin
                    if (word_in_range)
                    begin
                        state_reg <= ST_SCAN_CHK;
                    end
                    else
                    begin
                        res_ok_reg <= 1'b0;
                        state_reg  <= ST_DONE;
                    end
                end
                ST_SCAN_CHK:
                begin
                    if (scan_found)
                    begin
                        res_block_reg <= bba_pkg::POS_W'(grant_full);
                        hint_reg      <= scan_word_reg[AW-1:0];
                        state_reg     <= ST_DONE;
                    end
                    else
                    begin
                        scan_word_reg <= scan_word_reg + WCNT_W'(1);
                        state_reg     <= ST_SCAN_RD;
                    end
                end
                ST_MOD_RD:
                begin
                    state_reg <= ST_MOD_WR;
                end
                ST_MOD_WR:
                begin
                    // A freed block below the hint pulls the hint down.
                    if ((cmd_reg == bba_pkg::CMD_FREE) && (pos_word < hint_reg))
                    begin
                        hint_reg <= pos_word;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    // Hold until the output register is free or drains now.
                    if (load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign request.ready          = (state_reg == ST_IDLE);
    assign response.valid         = out_valid_reg;
    assign response.ok            = out_ok_reg;
    assign response.granted_block = out_block_reg;

    `BBA_ASSERT_IMPLIES(a_fail_no_block, clk, rst_n,
        out_valid_reg && !out_ok_reg, out_block_reg == '0,
        "failed allocate carries a nonzero block")
    `BBA_ASSERT_IMPLIES(a_grant_in_limit, clk, rst_n,
        out_valid_reg && out_ok_reg && (out_block_reg != '0),
        bba_pkg::SIZE_W'(out_block_reg) < limit,
        "granted block at or above the search limit")
    `BBA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n,
        request.valid && request.ready, state_reg != ST_IDLE,
        "sequencer stayed idle after taking an item")
    `BBA_ASSERT_IMPLIES(a_write_states, clk, rst_n,
        ram_we,
        (state_reg == ST_CLEAR) || (state_reg == ST_SCAN_CHK) || (state_reg == ST_MOD_WR),
        "bitmap written outside clear, allocate or modify")

endmodule

// ----- test/bitmap_block_allocator_unit_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_block_allocator_unit: a directed table,
// then random allocate/free/reserve traffic under several size settings.
// Depends on bba_pkg, bba_cmd_if, bba_res_if and the allocator RTL.
module bitmap_block_allocator_unit_test;

    // The package names three commands; code 3 is the unused one.
    localparam logic [bba_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Cycles without any handshake before the run is declared hung. The worst
    // honest gap is a full-bitmap scan plus a long stall.
    localparam int HANG_LIMIT       = 20000;
    // Let a full scan's worth of cycles pass at the end to catch stray results.
    localparam int TAIL_CYCLES      = 300;
    localparam int RANDOM_PER_PHASE = 321;
    localparam int NUM_PHASES       = 6;

    // One row of the directed table: either a size write or an item, with the
    // expected result typed in where it is obvious.
    typedef struct packed {
        bit                         is_cfg;
        logic [bba_pkg::SIZE_W-1:0] size_value;
        logic [bba_pkg::CMD_W-1:0]  cmd;
        logic [bba_pkg::POS_W-1:0]  pos;
        bit                         typed;
        logic                       ok;
        logic [bba_pkg::POS_W-1:0]  grant;
    } plan_row_t;

    typedef struct packed {
        logic                      ok;
        logic [bba_pkg::POS_W-1:0] grant;
    } outcome_t;

    localparam plan_row_t DIRECTED_PLAN [26] = '{
        // Fresh after reset: lowest blocks first.
        '{1'b0, 13'd0,    bba_pkg::CMD_ALLOC,   12'hFFF, 1'b1, 1'b1, 12'd0},
        '{1'b0, 13'd0,    bba_pkg::CMD_ALLOC,   12'h000, 1'b1, 1'b1, 12'd1},
        // Top block: reserve it, then reserve it again while used.
        '{1'b0, 13'd0,    bba_pkg::CMD_RESERVE, 12'hFFF, 1'b1, 1'b1, 12'd0},
        '{1'b0, 13'd0,    bba_pkg::CMD_RESERVE, 12'hFFF, 1'b0, 1'b0, 12'd0},
        // Free block 0 and get it back.
        '{1'b0, 13'd0,    bba_pkg::CMD_FREE,    12'h000, 1'b1, 1'b1, 12'd0},
        '{1'b0, 13'd0,    bba_pkg::CMD_ALLOC,   12'h800, 1'b1, 1'b1, 12'd0},
        // Free the top block twice: the second frees an already free block.
        '{1'b0, 13'd0,    bba_pkg::CMD_FREE,    12'hFFF, 1'b1, 1'b1, 12'd0},
        '{1'b0, 13'd0,    bba_pkg::CMD_FREE,    12'hFFF, 1'b0, 1'b0, 12'd0},
        '{1'b0, 13'd0,    bba_pkg::CMD_RESERVE, 12'h002, 1'b0, 1'b0, 12'd0},
        '{1'b0, 13'd0,    bba_pkg::CMD_ALLOC,   12'h7FF, 1'b0, 1'b0, 12'd0},
        // Unused code: no effect, plain success.
        '{1'b0, 13'd0,    CMD_UNUSED,           12'hFFF, 1'b1, 1'b1, 12'd0},
        '{1'b0, 13'd0,    CMD_UNUSED,           12'hAAA, 1'b1, 1'b1, 12'd0},
        // Size zero: allocate must fail; reserve above the size still lands.
        '{1'b1, 13'd0,    bba_pkg::CMD_ALLOC,   12'h000, 1'b0, 1'b0, 12'd0},
        '{1'b0, 13'd0,    bba_pkg::CMD_ALLOC,   12'h000, 1'b1, 1'b0, 12'd0},
        '{1'b0, 13'd0,    bba_pkg::CMD_RESERVE, 12'h005, 1'b1, 1'b1, 12'd0},
        '{1'b0, 13'd0,    bba_pkg::CMD_FREE,    12'h001, 1'b0, 1'b0, 12'd0},
        '{1'b0, 13'd0,    bba_pkg::CMD_ALLOC,   12'h555, 1'b1, 1'b0, 12'd0},
        // Size one: block 0 is taken, so fail until it is freed.
        '{1'b1, 13'd1,    bba_pkg::CMD_ALLOC,   12'h000, 1'b0, 1'b0, 12'd0},
        '{1'b0, 13'd0,    bba_pkg::CMD_ALLOC,   12'h000, 1'b1, 1'b0, 12'd0},
        '{1'b0, 13'd0,    bba_pkg::CMD_FREE,    12'h000, 1'b0, 1'b0, 12'd0},
        '{1'b0, 13'd0,    bba_pkg::CMD_ALLOC,   12'h000, 1'b1, 1'b1, 12'd0},
        // Largest size: the search limit saturates at the block count.
        '{1'b1, 13'd8191, bba_pkg::CMD_ALLOC,   12'h000, 1'b0, 1'b0, 12'd0},
        '{1'b0, 13'd0,    bba_pkg::CMD_ALLOC,   12'h000, 1'b0, 1'b0, 12'd0},
        '{1'b0, 13'd0,    bba_pkg::CMD_ALLOC,   12'h000, 1'b0, 1'b0, 12'd0},
        '{1'b0, 13'd0,    bba_pkg::CMD_RESERVE, 12'h555, 1'b0, 1'b0, 12'd0},
        '{1'b0, 13'd0,    bba_pkg::CMD_FREE,    12'h555, 1'b0, 1'b0, 12'd0}
    };

    // Size settings for the random phases: small ones fill up and exercise
    // refusals and holes, the large ones exercise long scans and saturation.
    localparam logic [bba_pkg::SIZE_W-1:0] PHASE_SIZES [NUM_PHASES] = '{
        13'd40, 13'd1, 13'd33, 13'd4096, 13'd97, 13'd8191
    };

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [bba_pkg::SIZE_W-1:0] cfg_wdata;

    bba_cmd_if request_ch ();
    bba_res_if response_ch ();

    bitmap_block_allocator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .request   (request_ch),
        .response  (response_ch)
    );

    // Shadow of the block: one usage bit per block and the size register.
    logic [bba_pkg::ADDRESSABLE-1:0] block_in_use;
    logic [bba_pkg::SIZE_W-1:0]      size_setting;

    outcome_t pending_results [$];

    // Idle rates in percent; switched between phases.
    int src_idle_pct   = 29;
    int sink_stall_pct = 72;

    int fault_count     = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int cfg_writes      = 0;
    int allocs_granted  = 0;
    int allocs_refused  = 0;
    int quiet_cycles    = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one item to the shadow state and return what the block must answer.
    function automatic outcome_t apply_to_bitmap(input logic [bba_pkg::CMD_W-1:0] cmd,
                                                 input logic [bba_pkg::POS_W-1:0] pos);
        outcome_t res;
        int       limit;
        int       blk;
        res.ok    = 1'b1;
        res.grant = '0;
        case (cmd)
            bba_pkg::CMD_ALLOC:
            begin
                // Search limit saturates at the number of nameable blocks.
                limit = (int'(size_setting) > bba_pkg::ADDRESSABLE) ? bba_pkg::ADDRESSABLE
                                                                    : int'(size_setting);
                blk = 0;
                while (blk < limit && block_in_use[blk])
                    blk++;
                if (blk < limit)
                begin
                    block_in_use[blk] = 1'b1;
                    res.grant = blk[bba_pkg::POS_W-1:0];
                    allocs_granted++;
                end
                else
                begin
                    res.ok = 1'b0;
                    allocs_refused++;
                end
            end
            bba_pkg::CMD_FREE:    block_in_use[pos] = 1'b0;
            bba_pkg::CMD_RESERVE: block_in_use[pos] = 1'b1;
            default: ;
        endcase
        return res;
    endfunction

    // Present one item, with random gaps, and hold it until accepted. On
    // acceptance, queue the typed expectation or the shadow's answer.
    task automatic send_command(input logic [bba_pkg::CMD_W-1:0] cmd,
                                input logic [bba_pkg::POS_W-1:0] pos,
                                input bit typed, input outcome_t typed_res);
        outcome_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            request_ch.valid <= 1'b0;
            @(posedge clk);
        end
        request_ch.valid    <= 1'b1;
        request_ch.command  <= cmd;
        request_ch.position <= pos;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
        predicted = apply_to_bitmap(cmd, pos);
        pending_results.push_back(typed ? typed_res : predicted);
        items_sent++;
    endtask

    // Drop valid and hold until every queued result has come back.
    task automatic wait_for_drain();
        request_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Size writes happen only with the block idle.
    task automatic write_size(input logic [bba_pkg::SIZE_W-1:0] value);
        wait_for_drain();
        cfg_we       <= 1'b1;
        cfg_wdata    <= value;
        size_setting  = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    // Random item: allocate about half the time, frees and reserves mostly
    // inside the managed range, plus some unused codes.
    task automatic pick_random_item(output logic [bba_pkg::CMD_W-1:0] cmd,
                                    output logic [bba_pkg::POS_W-1:0] pos);
        int roll;
        int limit;
        roll  = $urandom_range(0, 99);
        limit = (int'(size_setting) > bba_pkg::ADDRESSABLE) ? bba_pkg::ADDRESSABLE
                                                            : int'(size_setting);
        if (roll < 50)
            cmd = bba_pkg::CMD_ALLOC;
        else if (roll < 73)
            cmd = bba_pkg::CMD_FREE;
        else if (roll < 93)
            cmd = bba_pkg::CMD_RESERVE;
        else
            cmd = CMD_UNUSED;
        if (cmd != CMD_UNUSED && cmd != bba_pkg::CMD_ALLOC && limit > 0
            && $urandom_range(0, 99) < 70)
            pos = bba_pkg::POS_W'($urandom_range(0, limit - 1));
        else
            pos = bba_pkg::POS_W'($urandom_range(0, bba_pkg::ADDRESSABLE - 1));
    endtask

    // Receiver: check each accepted result against the oldest expectation,
    // then decide the next cycle's ready.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && response_ch.valid && response_ch.ready)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: ok=%0b block=%0d",
                             response_ch.ok, response_ch.granted_block);
            end
            else
            begin
                want = pending_results.pop_front();
                if (response_ch.ok !== want.ok || response_ch.granted_block !== want.grant)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"mismatch on result %0d: expected ok=%0b block=%0d,",
                                  " got ok=%0b block=%0d"},
                                 results_checked, want.ok, want.grant,
                                 response_ch.ok, response_ch.granted_block);
                end
            end
        end
        response_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Watchdog: count cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if ((request_ch.valid && request_ch.ready) || (response_ch.valid && response_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("no handshake for %0d cycles, %0d results outstanding",
                     HANG_LIMIT, pending_results.size());
            $display("FAIL bitmap_block_allocator_unit");
            $finish;
        end
    end

    initial
    begin
        plan_row_t                 row;
        outcome_t                  typed_res;
        logic [bba_pkg::CMD_W-1:0] cmd;
        logic [bba_pkg::POS_W-1:0] pos;

        // Drive every input but the result ready to a known value before the first edge.
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= bba_pkg::SIZE_RESET;
        request_ch.valid    <= 1'b0;
        request_ch.command  <= bba_pkg::CMD_ALLOC;
        request_ch.position <= '0;
        block_in_use         = '0;
        size_setting         = bba_pkg::SIZE_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; the clearing pass after reset simply
        // shows up as a long wait for the first ready.
        foreach (DIRECTED_PLAN[i])
        begin
            row = DIRECTED_PLAN[i];
            if (row.is_cfg)
                write_size(row.size_value);
            else
            begin
                typed_res.ok    = row.ok;
                typed_res.grant = row.grant;
                send_command(row.cmd, row.pos, row.typed, typed_res);
            end
        end

        // Random phases: receiver-heavy stalling, then sender-heavy idling, then none.
        typed_res = '0;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase < 2)
            begin
                src_idle_pct   = 29;
                sink_stall_pct = 72;
            end
            else if (phase < 4)
            begin
                src_idle_pct   = 72;
                sink_stall_pct = 29;
            end
            else
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            write_size(PHASE_SIZES[phase]);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // Hold off halfway through so the pipe runs completely dry.
                if (n == RANDOM_PER_PHASE / 2)
                    wait_for_drain();
                pick_random_item(cmd, pos);
                send_command(cmd, pos, 1'b0, typed_res);
            end
        end

        // Drain, then give the block time to emit anything it should not.
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_results.size());
            fault_count += pending_results.size();
        end

        $display("ran %0d items over %0d size writes (sizes 0 to 8191, three idle modes)",
                 items_sent, cfg_writes);
        $display("allocations granted %0d, refused %0d; %0d results checked, %0d faults",
                 allocs_granted, allocs_refused, results_checked, fault_count);
        if (fault_count == 0)
            $display("PASS bitmap_block_allocator_unit");
        else
            $display("FAIL bitmap_block_allocator_unit");
        $finish;
    end

endmodule
